[design/vgf_pkg.sv]
// ----------------------------------------------------------------------------
// vgf_pkg
// Shared types and constants for the voxel-grid first-point filter.
// ----------------------------------------------------------------------------
package vgf_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 4096;
   localparam int unsigned MAX_PROBES_DEF    = 16;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned VSIZE_W = 31;
   localparam int unsigned RAW_W   = 32;
   localparam int unsigned KEPT_W  = 13;

   localparam logic [VSIZE_W-1:0] VSIZE_RESET = 31'd6554;

   localparam logic [31:0] HASH_MUL_X = 32'd73856093;
   localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
   localparam logic [31:0] HASH_MUL_Z = 32'd83492791;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture point, start divide
      logic div_step;    // one quotient bit
      logic next_axis;   // store quotient, load next axis
      logic hash_mul;    // register products
      logic hash_fold;   // fold hash into start slot
      logic clr_write;   // clearing pass write
      logic rd_issue;    // read probe slot
      logic probe_next;  // advance probe address
      logic ins_write;   // write key into slot
      logic count_raw;
      logic count_kept;
      logic emit;
      logic emit_new;
      logic emit_drop;
      logic emit_full;
   } vgf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic invalid;
      logic div_last;
      logic axis_last;
      logic slot_used;
      logic key_match;
      logic probe_last;
      logic clr_last;
   } vgf_sts_type;

endpackage

[design/voxel_grid_first_point_filter.sv]
// ----------------------------------------------------------------------------
// voxel_grid_first_point_filter
// An invalid point is reported without dividing; a valid one runs three
//   32-step serial divides, then up to MAX_PROBES reads of the table.
// Throughput: one transaction at a time; start is taken when busy is low.
// Reset: synchronous; a clearing sweep of all TABLE_ENTRIES slots holds busy high.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module voxel_grid_first_point_filter #(
   parameter int unsigned TABLE_ENTRIES = vgf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_PROBES    = vgf_pkg::MAX_PROBES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_z,
   input  logic                                req_point_invalid,
   input  logic                                csr_we,
   input  logic [vgf_pkg::VSIZE_W-1:0]         csr_wdata,
   output logic                                rsp_valid,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_voxel_x,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_voxel_y,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_voxel_z,
   output logic                                rsp_new_voxel,
   output logic                                rsp_dropped_invalid,
   output logic                                rsp_table_full,
   output logic [vgf_pkg::RAW_W-1:0]           rsp_raw_count,
   output logic [vgf_pkg::KEPT_W-1:0]          rsp_kept_count
);
   import vgf_pkg::*;

   vgf_cmd_type cmd;
   vgf_sts_type sts;

   vgf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   vgf_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_PROBES    (MAX_PROBES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_point_z         (req_point_z),
      .req_point_invalid   (req_point_invalid),
      .rsp_valid           (rsp_valid),
      .rsp_voxel_x         (rsp_voxel_x),
      .rsp_voxel_y         (rsp_voxel_y),
      .rsp_voxel_z         (rsp_voxel_z),
      .rsp_new_voxel       (rsp_new_voxel),
      .rsp_dropped_invalid (rsp_dropped_invalid),
      .rsp_table_full      (rsp_table_full),
      .rsp_raw_count       (rsp_raw_count),
      .rsp_kept_count      (rsp_kept_count)
   );

endmodule

[design/vgf_datapath.sv]
// ----------------------------------------------------------------------------
// vgf_datapath
// Restoring divider shared over three axes, hash, slot table and counters.
// ----------------------------------------------------------------------------
module vgf_datapath #(
   parameter int unsigned TABLE_ENTRIES = vgf_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_PROBES    = vgf_pkg::MAX_PROBES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vgf_pkg::vgf_cmd_type                cmd,
   output vgf_pkg::vgf_sts_type                sts,
   input  logic                                csr_we,
   input  logic [vgf_pkg::VSIZE_W-1:0]         csr_wdata,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [vgf_pkg::COORD_W-1:0]  req_point_z,
   input  logic                                req_point_invalid,
   output logic                                rsp_valid,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_voxel_x,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_voxel_y,
   output logic signed [vgf_pkg::COORD_W-1:0]  rsp_voxel_z,
   output logic                                rsp_new_voxel,
   output logic                                rsp_dropped_invalid,
   output logic                                rsp_table_full,
   output logic [vgf_pkg::RAW_W-1:0]           rsp_raw_count,
   output logic [vgf_pkg::KEPT_W-1:0]          rsp_kept_count
);
   import vgf_pkg::*;

   localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
   localparam int unsigned PW  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   localparam int unsigned KW  = 3 * COORD_W;
   localparam logic [PW-1:0] PROBE_LAST = PW'(MAX_PROBES - 1);

   // configuration
   logic [VSIZE_W-1:0] vsize_ff;
   always_ff @(posedge clock) begin
      if (reset) vsize_ff <= VSIZE_RESET;
      else if (csr_we) vsize_ff <= csr_wdata;
   end

   // captured point
   logic [COORD_W-1:0] pt_ff [3];
   logic               inv_ff;
   logic [1:0]         axis_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
         inv_ff   <= req_point_invalid;
      end
   end

   // restoring divide of |num| by den, sign fix on completion
   logic [VSIZE_W-1:0] den;
   logic [COORD_W-1:0] num_sel;
   logic               neg_sel;
   logic [COORD_W-1:0] mag_sel;
   logic [COORD_W-1:0] dq_ff;
   logic [VSIZE_W:0]   rem_ff;
   logic [4:0]         dcnt_ff;
   logic               dneg_ff;
   logic [VSIZE_W+1:0] trial;
   logic [VSIZE_W:0]   rem_sh;
   logic [COORD_W-1:0] q_fix;
   logic [COORD_W-1:0] key_ff [3];

   assign den     = (vsize_ff == '0) ? VSIZE_W'(1) : vsize_ff;
   always_comb begin
      case (cmd.load)
         1'b1:    num_sel = req_point_x;
         default: num_sel = (axis_ff == 2'd0) ? pt_ff[1] : pt_ff[2];
      endcase
   end
   assign neg_sel = num_sel[COORD_W-1];
   assign mag_sel = neg_sel ? (~num_sel + 1'b1) : num_sel;
   assign rem_sh  = {rem_ff[VSIZE_W-1:0], dq_ff[COORD_W-1]};
   assign trial   = {1'b0, rem_sh} - {2'b00, den};
   // floor for negatives: -(q) - (rem != 0)
   assign q_fix   = dneg_ff ? (~dq_ff + ((rem_ff != '0) ? 1'b0 : 1'b1)) : dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.next_axis) begin
         dq_ff   <= mag_sel;
         rem_ff  <= '0;
         dcnt_ff <= '0;
         dneg_ff <= neg_sel;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 5'd1;
         if (!trial[VSIZE_W+1]) begin
            rem_ff <= trial[VSIZE_W:0];
            dq_ff  <= {dq_ff[COORD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            dq_ff  <= {dq_ff[COORD_W-2:0], 1'b0};
         end
      end
      if (cmd.load) axis_ff <= 2'd0;
      else if (cmd.next_axis) axis_ff <= axis_ff + 2'd1;
      if (cmd.next_axis) key_ff[axis_ff] <= q_fix;
   end

   // hash
   logic [31:0] hx_ff, hy_ff, hz_ff;
   logic [AW-1:0] addr_ff;
   logic [PW-1:0] probe_ff;
   always_ff @(posedge clock) begin
      if (cmd.hash_mul) begin
         hx_ff <= key_ff[0] * HASH_MUL_X;
         hy_ff <= key_ff[1] * HASH_MUL_Y;
         hz_ff <= key_ff[2] * HASH_MUL_Z;
      end
      if (cmd.hash_fold) begin
         addr_ff  <= AW'(hx_ff ^ hy_ff ^ hz_ff);
         probe_ff <= '0;
      end else if (cmd.probe_next) begin
         addr_ff  <= addr_ff + 1'b1;
         probe_ff <= probe_ff + 1'b1;
      end
   end

   // slot table, cleared by a sweep after reset
   logic [AW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_write) clr_ff <= clr_ff + 1'b1;
   end

   logic          used_mem [TABLE_ENTRIES];
   logic [KW-1:0] key_mem  [TABLE_ENTRIES];
   logic          used_rd_ff;
   logic [KW-1:0] key_rd_ff;
   logic [KW-1:0] key_cat;
   assign key_cat = {key_ff[2], key_ff[1], key_ff[0]};

   always_ff @(posedge clock) begin
      if (cmd.clr_write) used_mem[clr_ff] <= 1'b0;
      else if (cmd.ins_write) used_mem[addr_ff] <= 1'b1;
      if (cmd.rd_issue) used_rd_ff <= used_mem[addr_ff];
   end
   always_ff @(posedge clock) begin
      if (cmd.ins_write) key_mem[addr_ff] <= key_cat;
      if (cmd.rd_issue) key_rd_ff <= key_mem[addr_ff];
   end

   // counters
   logic [RAW_W-1:0]  raw_ff;
   logic [KEPT_W-1:0] kept_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff  <= '0;
         kept_ff <= '0;
      end else begin
         if (cmd.count_raw && raw_ff != '1) raw_ff <= raw_ff + 1'b1;
         if (cmd.count_kept && kept_ff != '1) kept_ff <= kept_ff + 1'b1;
      end
   end

   // result register
   logic valid_ff;
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= cmd.emit;
   end
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_voxel_x         <= cmd.emit_drop ? '0 : key_ff[0];
         rsp_voxel_y         <= cmd.emit_drop ? '0 : key_ff[1];
         rsp_voxel_z         <= cmd.emit_drop ? '0 : key_ff[2];
         rsp_new_voxel       <= cmd.emit_new;
         rsp_dropped_invalid <= cmd.emit_drop;
         rsp_table_full      <= cmd.emit_full;
         rsp_raw_count       <= raw_ff;
         rsp_kept_count      <= kept_ff + KEPT_W'(cmd.emit_new && kept_ff != '1);
      end
   end
   assign rsp_valid = valid_ff;

   assign sts.invalid    = inv_ff;
   assign sts.div_last   = (dcnt_ff == 5'd31);
   assign sts.axis_last  = (axis_ff == 2'd2);
   assign sts.slot_used  = used_rd_ff;
   assign sts.key_match  = (key_rd_ff == key_cat);
   assign sts.probe_last = (probe_ff == PROBE_LAST);
   assign sts.clr_last   = (clr_ff == '1);

endmodule

[design/vgf_ctrl.sv]
// ----------------------------------------------------------------------------
// vgf_ctrl
// Sequencer: clearing sweep, divide, hash, probe, insert, report.
// ----------------------------------------------------------------------------
module vgf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vgf_pkg::vgf_sts_type sts,
   output vgf_pkg::vgf_cmd_type cmd
);
   import vgf_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CHECK = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_NEXT  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_FOLD  = 4'd6;
   localparam logic [3:0] ST_READ  = 4'd7;
   localparam logic [3:0] ST_WAIT  = 4'd8;
   localparam logic [3:0] ST_EVAL  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.invalid) begin
               cmd.emit      = 1'b1;
               cmd.emit_drop = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.count_raw = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.next_axis = 1'b1;
            state_in = sts.axis_last ? ST_MUL : ST_DIV;
         end
         ST_MUL: begin
            cmd.hash_mul = 1'b1;
            state_in     = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.hash_fold = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: state_in = ST_EVAL;
         ST_EVAL: begin
            if (!sts.slot_used) begin
               cmd.ins_write  = 1'b1;
               cmd.count_kept = 1'b1;
               cmd.emit       = 1'b1;
               cmd.emit_new   = 1'b1;
               state_in       = ST_IDLE;
            end else if (sts.key_match) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.probe_last) begin
               cmd.emit      = 1'b1;
               cmd.emit_full = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = ST_READ;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for voxel_grid_first_point_filter: directed points at
// the coordinate and voxel-size extremes, a forced probe overflow, then
// clustered random point clouds under several voxel sizes, each checked
// against an in-bench model of the voxel hash set.
// ----------------------------------------------------------------------------
module testbench;
   import vgf_pkg::*;

   localparam int unsigned ENTRIES   = TABLE_ENTRIES_DEF;
   localparam int unsigned PROBES    = MAX_PROBES_DEF;
   localparam int          WDOG_MAX  = 20000;
   localparam int          SETTLE    = 200;
   localparam int          N_RANDOM  = 1820;

   typedef struct {
      logic [31:0]       vx, vy, vz;
      logic              is_new, dropped, full;
      logic [RAW_W-1:0]  raw;
      logic [KEPT_W-1:0] kept;
   } voxel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic req_point_invalid = 1'b0;
   logic csr_we = 1'b0;
   logic [VSIZE_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [COORD_W-1:0] rsp_voxel_x, rsp_voxel_y, rsp_voxel_z;
   logic rsp_new_voxel, rsp_dropped_invalid, rsp_table_full;
   logic [RAW_W-1:0]  rsp_raw_count;
   logic [KEPT_W-1:0] rsp_kept_count;

   voxel_grid_first_point_filter DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .req_point_invalid(req_point_invalid),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_voxel_x(rsp_voxel_x),
      .rsp_voxel_y(rsp_voxel_y), .rsp_voxel_z(rsp_voxel_z),
      .rsp_new_voxel(rsp_new_voxel), .rsp_dropped_invalid(rsp_dropped_invalid),
      .rsp_table_full(rsp_table_full), .rsp_raw_count(rsp_raw_count),
      .rsp_kept_count(rsp_kept_count)
   );

   always #1 clock = ~clock;

   // model state
   logic [VSIZE_W-1:0] model_vsize;
   bit                 slot_taken [ENTRIES];
   logic [95:0]        slot_voxel [ENTRIES];
   logic [RAW_W-1:0]   model_raw;
   logic [KEPT_W-1:0]  model_kept;

   voxel_result_type expected_voxels[$];
   int errors = 0;
   int n_items = 0, n_new = 0, n_hit = 0, n_full = 0, n_drop = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;

   function automatic logic [31:0] floor_index(logic [31:0] coord);
      longint num, den, q;
      num = longint'($signed(coord));
      den = (model_vsize == 0) ? 1 : longint'(model_vsize);
      q = num / den;
      if ((num % den) != 0 && num < 0) q -= 1;
      return q[31:0];
   endfunction

   function automatic voxel_result_type filter_point(logic [31:0] px, py, pz, logic inv);
      voxel_result_type r;
      logic [31:0] h, slot;
      logic [95:0] key;
      bit done;
      r = '{default: '0};
      if (inv) begin
         r.dropped = 1'b1;
      end else begin
         r.vx = floor_index(px);
         r.vy = floor_index(py);
         r.vz = floor_index(pz);
         if (model_raw != '1) model_raw++;
         key = {r.vx, r.vy, r.vz};
         h = (r.vx * HASH_MUL_X) ^ (r.vy * HASH_MUL_Y) ^ (r.vz * HASH_MUL_Z);
         done = 1'b0;
         for (int i = 0; i < PROBES && !done; i++) begin
            slot = (h % ENTRIES + i) % ENTRIES;
            if (!slot_taken[slot]) begin
               slot_taken[slot] = 1'b1;
               slot_voxel[slot] = key;
               if (model_kept != '1) model_kept++;
               r.is_new = 1'b1;
               done = 1'b1;
            end else if (slot_voxel[slot] == key) begin
               done = 1'b1;
            end
         end
         r.full = !done;
      end
      r.raw  = model_raw;
      r.kept = model_kept;
      return r;
   endfunction

   // checker
   always @(posedge clock) begin
      voxel_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_voxels.size() == 0) begin
            $display("%0t: unexpected result x=%0d", $time, rsp_voxel_x);
            errors++;
         end else begin
            e = expected_voxels.pop_front();
            if (rsp_voxel_x !== e.vx || rsp_voxel_y !== e.vy || rsp_voxel_z !== e.vz) begin
               $display("%0t: voxel exp (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
                        $signed(e.vx), $signed(e.vy), $signed(e.vz),
                        rsp_voxel_x, rsp_voxel_y, rsp_voxel_z);
               errors++;
            end
            if (rsp_new_voxel !== e.is_new || rsp_dropped_invalid !== e.dropped ||
                rsp_table_full !== e.full) begin
               $display("%0t: flags new/drop/full exp %b%b%b got %b%b%b", $time,
                        e.is_new, e.dropped, e.full,
                        rsp_new_voxel, rsp_dropped_invalid, rsp_table_full);
               errors++;
            end
            if (rsp_raw_count !== e.raw || rsp_kept_count !== e.kept) begin
               $display("%0t: counts raw/kept exp %0d/%0d got %0d/%0d", $time,
                        e.raw, e.kept, rsp_raw_count, rsp_kept_count);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WDOG_MAX) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic idle_gap();
      int n;
      if (!gaps_on) return;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      repeat (n) @(negedge clock);
   endtask

   task automatic send_point(logic [31:0] px, py, pz, logic inv);
      voxel_result_type r;
      idle_gap();
      while (busy) @(negedge clock);
      start = 1'b1;
      req_point_x = px; req_point_y = py; req_point_z = pz;
      req_point_invalid = inv;
      @(posedge clock);
      r = filter_point(px, py, pz, inv);
      expected_voxels.push_back(r);
      n_items++;
      if (r.dropped) n_drop++;
      else if (r.full) n_full++;
      else if (r.is_new) n_new++;
      else n_hit++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic wait_drain();
      while (expected_voxels.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_voxel_size(logic [VSIZE_W-1:0] size);
      wait_drain();
      csr_we = 1'b1;
      csr_wdata = size;
      @(negedge clock);
      model_vsize = size;
      csr_we = 1'b0;
   endtask

   task automatic test_extremes();
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h1, 32'hFFFF_E667, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0);
      send_point(32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      set_voxel_size(31'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 1'b0);
      set_voxel_size('0);
      send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h0, 32'h0, 32'h0, 1'b0);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   // keys differing by multiples of the table size share a start slot
   task automatic test_probe_overflow();
      logic [31:0] base;
      set_voxel_size(31'd1);
      base = $urandom_range(0, ENTRIES - 1);
      for (int j = 0; j <= PROBES; j++)
         send_point(base + j * ENTRIES, 32'h0, 32'h0, 1'b0);
      send_point(base, 32'h0, 32'h0, 1'b0);
      send_point(base + (PROBES + 1) * ENTRIES, 32'h0, 32'h0, 1'b0);
   endtask

   task automatic test_random_clouds();
      logic [31:0] cx[8], cy[8], cz[8];
      logic [31:0] px, py, pz;
      logic [VSIZE_W-1:0] sizes[6];
      int c, sel, span;
      sizes = '{31'd6554, 31'd1, 31'd65536, 31'd3, 31'h7FFF_FFFF, 31'd0};
      for (int phase = 0; phase < 6; phase++) begin
         set_voxel_size(phase < 5 ? sizes[phase] : VSIZE_W'($urandom_range(1, 500000)));
         gaps_on = (phase != 2);
         span = (phase == 1) ? 64 : 300000;
         foreach (cx[i]) begin
            cx[i] = $urandom; cy[i] = $urandom; cz[i] = $urandom;
         end
         for (int n = 0; n < N_RANDOM / 6; n++) begin
            sel = $urandom_range(0, 99);
            c = $urandom_range(0, 7);
            px = cx[c] + $urandom_range(0, span);
            py = cy[c] + $urandom_range(0, span);
            pz = cz[c] + $urandom_range(0, span);
            if (sel < 15) begin
               px = $urandom; py = $urandom; pz = $urandom;
            end
            send_point(px, py, pz, sel >= 88);
            if (n == 150) wait_drain();
         end
      end
   endtask

   initial begin
      model_vsize = VSIZE_RESET;
      model_raw = '0;
      model_kept = '0;
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_probe_overflow();
      test_random_clouds();
      wait_drain();
      $display("Covered %0d points: %0d new voxels, %0d repeats, %0d overflows, %0d invalid",
               n_items, n_new, n_hit, n_full, n_drop);
      $display("Voxel sizes from 0 to max, coordinates at both signed extremes");
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
